// ----- sv/pbt_pkg.sv -----
// ----------------------------------------------------------------------------
// pbt_pkg: shared constants of the trajectory evaluator
// Arctangent table, register codes, reset values and widths.
// ----------------------------------------------------------------------------
package pbt_pkg;

	localparam int HEADING_WIDTH = 18;
	localparam int ANG_FRAC      = 16;
	localparam int ANG_WIDTH     = 34;
	localparam int TABLE_LEN     = 24;

	localparam logic [0:0] REG_ARC_HEIGHT = 1'b0;
	localparam logic [0:0] REG_SPIN_LIMIT = 1'b1;

	localparam logic [22:0] ARC_HEIGHT_RESET = 23'd38400;
	localparam logic [16:0] SPIN_LIMIT_RESET = 17'd40960;

	localparam logic signed [ANG_WIDTH-1:0] HALF_TURN = 34'sd754974720; // 11520 << 16

	function automatic logic signed [ANG_WIDTH-1:0] atan_entry(input int idx);
		logic signed [ANG_WIDTH-1:0] r;
		case (idx)
			0: r = 34'sd188743680;
			1: r = 34'sd111421900;
			2: r = 34'sd58872272;
			3: r = 34'sd29884485;
			4: r = 34'sd15000234;
			5: r = 34'sd7507429;
			6: r = 34'sd3754631;
			7: r = 34'sd1877430;
			8: r = 34'sd938729;
			9: r = 34'sd469366;
			10: r = 34'sd234683;
			11: r = 34'sd117342;
			12: r = 34'sd58671;
			13: r = 34'sd29335;
			14: r = 34'sd14668;
			15: r = 34'sd7334;
			16: r = 34'sd3667;
			17: r = 34'sd1833;
			18: r = 34'sd917;
			19: r = 34'sd458;
			20: r = 34'sd229;
			21: r = 34'sd115;
			22: r = 34'sd57;
			23: r = 34'sd29;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// ----- sv/projectile_bezier_trajectory.sv -----
// ----------------------------------------------------------------------------
// projectile_bezier_trajectory: Bezier arc / straight line evaluator
// Channel   | dir | payload
// s_axis    | in  | start/end points, progress; tuser = curved, spinning
// m_axis    | out | pos_x/y/z, heading; tuser = arrived
// apb       | in  | arc_height (0x0), spin_limit (0x4)
// One request per cycle while the output is not stalled. Stages: setup
// stage, three interpolation cells (the prep stage runs beside the third),
// then one CORDIC cell per iteration (at most TABLE_LEN) and a rounding stage.
// The whole row advances when the last stage is empty or taken; a stalled output freezes it.
// Reset clears valid flags and the registers; payload is not reset.
// ----------------------------------------------------------------------------
module projectile_bezier_trajectory import pbt_pkg::*; #(
	parameter int COORD_WIDTH        = 24,
	parameter int PROGRESS_FRAC_BITS = 16,
	parameter int ANGLE_ITERATIONS   = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// start_x, start_y, start_z, end_x, end_y, end_z, progress, zero pad
	input  logic [((6*COORD_WIDTH+PROGRESS_FRAC_BITS+1+7)/8)*8-1:0] s_axis_tdata,
	// curved, spinning
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// pos_x, pos_y, pos_z, heading, zero pad
	output logic [((3*COORD_WIDTH+HEADING_WIDTH+7)/8)*8-1:0] m_axis_tdata,
	// arrived
	output logic        m_axis_tuser,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int W   = COORD_WIDTH;
	localparam int F   = PROGRESS_FRAC_BITS;
	localparam int NIT = (ANGLE_ITERATIONS < TABLE_LEN) ? ANGLE_ITERATIONS : TABLE_LEN;
	localparam int VW  = W + 6;
	localparam int NST = 5 + NIT;
	localparam int OW  = ((3*W+HEADING_WIDTH+7)/8)*8;

	logic [22:0] arc_height_q;
	logic [16:0] spin_limit_q;
	logic        wr;

	assign pready = 1'b1;
	assign wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arc_height_q <= ARC_HEIGHT_RESET;
			spin_limit_q <= SPIN_LIMIT_RESET;
		end else if (wr && paddr[1:0] == 2'b00 && paddr[2] == REG_ARC_HEIGHT) begin
			arc_height_q <= pwdata[22:0];
		end else if (wr && paddr[1:0] == 2'b00 && paddr[2] == REG_SPIN_LIMIT) begin
			spin_limit_q <= pwdata[16:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_ARC_HEIGHT) begin
			prdata = {9'd0, arc_height_q};
		end else begin
			prdata = {15'd0, spin_limit_q};
		end
	end

	// pipeline control
	logic [NST-1:0] vld_q;
	logic           adv;

	assign adv = !vld_q[NST-1] || m_axis_tready;
	assign s_axis_tready = adv;
	assign m_axis_tvalid = vld_q[NST-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NST-2:0], s_axis_tvalid};
		end
	end

	// input unpack
	logic signed [W-1:0] sp [3];
	logic signed [W-1:0] ep [3];
	logic [F:0]          prog;
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			sp[k] = s_axis_tdata[k*W +: W];
			ep[k] = s_axis_tdata[(k+3)*W +: W];
		end
		prog = s_axis_tdata[6*W +: F+1];
	end

	// stage 1: control points, clamp
	logic signed [W-1:0] p0_s1 [3];
	logic signed [W-1:0] c1_s1 [3];
	logic signed [W-1:0] c2_s1 [3];
	logic signed [W-1:0] p3_s1 [3];
	logic [F:0]          t_s1;
	logic                curved_s1, spin_s1, arr_s1, right_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			logic signed [W:0]   d, q;
			logic signed [W+1:0] yt;
			for (int k = 0; k < 3; k++) begin
				d = (W+1)'(ep[k]) - (W+1)'(sp[k]);
				q = (d < 0) ? -((-d) >>> 2) : (d >>> 2);
				p0_s1[k] <= sp[k];
				p3_s1[k] <= ep[k];
				if (s_axis_tuser[0]) begin
					c1_s1[k] <= W'((W+1)'(sp[k]) + q);
					c2_s1[k] <= W'((W+1)'(ep[k]) - q);
				end else begin
					// straight line: a cubic with control points at the ends
					// is not linear in t, so the cells carry start/end instead
					c1_s1[k] <= sp[k];
					c2_s1[k] <= ep[k];
				end
			end
			yt = (W+2)'((sp[1] > ep[1]) ? sp[1] : ep[1]) + (W+2)'($signed({1'b0, arc_height_q}));
			if (s_axis_tuser[0]) begin
				if (yt > $signed((W+2)'({1'b0, {(W-1){1'b1}}}))) begin
					c1_s1[1] <= {1'b0, {(W-1){1'b1}}};
					c2_s1[1] <= {1'b0, {(W-1){1'b1}}};
				end else begin
					c1_s1[1] <= W'(yt);
					c2_s1[1] <= W'(yt);
				end
			end
			t_s1      <= (prog > (F+1)'(1 << F)) ? (F+1)'(1 << F) : prog;
			arr_s1    <= prog >= (F+1)'(1 << F);
			curved_s1 <= s_axis_tuser[0];
			spin_s1   <= s_axis_tuser[1];
			right_s1  <= (W+1)'(ep[0]) - (W+1)'(sp[0]) > 0;
		end
	end

	// level 1 cell: straight mode uses lane 0 only (start to end)
	logic signed [W-1:0] la1 [9];
	logic signed [W-1:0] lb1 [9];
	logic signed [W-1:0] l1  [9];
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			la1[3*k]   = p0_s1[k];
			lb1[3*k]   = curved_s1 ? c1_s1[k] : p3_s1[k];
			la1[3*k+1] = c1_s1[k];
			lb1[3*k+1] = c2_s1[k];
			la1[3*k+2] = c2_s1[k];
			lb1[3*k+2] = p3_s1[k];
		end
	end
	pbt_lerp_cell #(.W(W), .F(F), .N(9)) u_lv1 (
		.clk(clk), .en(adv), .t(t_s1), .a(la1), .b(lb1), .y(l1));

	logic [F:0] t_s2;
	logic curved_s2, spin_s2, arr_s2, right_s2;
	always_ff @(posedge clk) begin
		if (adv) begin
			t_s2 <= t_s1; curved_s2 <= curved_s1; spin_s2 <= spin_s1;
			arr_s2 <= arr_s1; right_s2 <= right_s1;
		end
	end

	logic signed [W-1:0] la2 [6];
	logic signed [W-1:0] lb2 [6];
	logic signed [W-1:0] l2  [6];
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			la2[2*k]   = l1[3*k];
			lb2[2*k]   = l1[3*k+1];
			la2[2*k+1] = l1[3*k+1];
			lb2[2*k+1] = l1[3*k+2];
		end
	end
	pbt_lerp_cell #(.W(W), .F(F), .N(6)) u_lv2 (
		.clk(clk), .en(adv), .t(t_s2), .a(la2), .b(lb2), .y(l2));

	logic [F:0] t_s3;
	logic curved_s3, spin_s3, arr_s3, right_s3;
	logic signed [W-1:0] lin_s3 [3];
	always_ff @(posedge clk) begin
		if (adv) begin
			t_s3 <= t_s2; curved_s3 <= curved_s2; spin_s3 <= spin_s2;
			arr_s3 <= arr_s2; right_s3 <= right_s2;
			for (int k = 0; k < 3; k++) lin_s3[k] <= l1[3*k];
		end
	end

	localparam int W3 = (W > 19) ? W : 19;
	logic signed [W3-1:0] la3w [4];
	logic signed [W3-1:0] lb3w [4];
	logic signed [W3-1:0] l3w  [4];
	logic signed [W-1:0]  l3   [3];
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			la3w[k] = W3'(l2[2*k]);
			lb3w[k] = W3'(l2[2*k+1]);
			l3[k]   = W'(l3w[k]);
		end
		// spin ramp shares the level
		la3w[3] = '0;
		lb3w[3] = W3'($signed({1'b0, spin_limit_q}));
	end
	pbt_lerp_cell #(.W(W3), .F(F), .N(4)) u_lv3_dummy_free (
		.clk(clk), .en(adv), .t(t_s3), .a(la3w), .b(lb3w), .y(l3w));

	// straight-mode direction kept at full width (end - start may wrap W bits)
	logic signed [W:0] dfx_s1, dfy_s1, dfx_s2, dfy_s2, dfx_s3, dfy_s3;
	always_ff @(posedge clk) begin
		if (adv) begin
			dfx_s1 <= (W+1)'(ep[0]) - (W+1)'(sp[0]);
			dfy_s1 <= (W+1)'(ep[1]) - (W+1)'(sp[1]);
			dfx_s2 <= dfx_s1; dfy_s2 <= dfy_s1;
			dfx_s3 <= dfx_s2; dfy_s3 <= dfy_s2;
		end
	end

	// stage 4: CORDIC vector; position (curved mode) and spin come off the level 3 cell
	logic signed [W-1:0] pos_s4 [3];
	logic signed [W-1:0] lin_s4 [3];
	logic signed [VW-1:0] vx_s4, vy_s4;
	logic signed [ANG_WIDTH-1:0] z_s4;
	logic arr_s4, spinsel_s4, ax_s4, curved_s4, right_s4;
	logic signed [HEADING_WIDTH-1:0] spin_s4, axang_s4, spin_raw;
	always_ff @(posedge clk) begin
		if (adv) begin
			logic signed [W:0] x, y;
			for (int k = 0; k < 3; k++) lin_s4[k] <= lin_s3[k];
			if (curved_s3) begin
				x = (W+1)'(l2[1]) - (W+1)'(l2[0]);
				y = (W+1)'(l2[3]) - (W+1)'(l2[2]);
			end else begin
				x = dfx_s3;
				y = dfy_s3;
			end
			ax_s4 <= (x == 0) || (y == 0);
			axang_s4 <= (y == 0) ? ((x < 0) ? 18'sd11520 : 18'sd0)
			                     : ((y > 0) ? 18'sd5760 : -18'sd5760);
			if (x < 0) begin
				vx_s4 <= -VW'(x); vy_s4 <= -VW'(y);
				z_s4  <= (y > 0) ? HALF_TURN : -HALF_TURN;
			end else begin
				vx_s4 <= VW'(x); vy_s4 <= VW'(y);
				z_s4  <= '0;
			end
			curved_s4 <= curved_s3;
			right_s4 <= right_s3;
			spinsel_s4 <= curved_s3 && spin_s3;
			arr_s4 <= arr_s3;
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) pos_s4[k] = curved_s4 ? l3[k] : lin_s4[k];
		spin_raw = HEADING_WIDTH'(l3w[3]);
		spin_s4 = right_s4 ? -spin_raw : spin_raw;
	end

	// CORDIC row
	logic signed [VW-1:0]        cx [NIT+1];
	logic signed [VW-1:0]        cy [NIT+1];
	logic signed [ANG_WIDTH-1:0] cz [NIT+1];
	logic signed [W-1:0] pos_d [NIT+1][3];
	logic arr_d [NIT+1], ss_d [NIT+1], ax_d [NIT+1];
	logic signed [HEADING_WIDTH-1:0] sh_d [NIT+1], ah_d [NIT+1];

	assign cx[0] = vx_s4; assign cy[0] = vy_s4; assign cz[0] = z_s4;
	assign pos_d[0] = pos_s4; assign arr_d[0] = arr_s4; assign ss_d[0] = spinsel_s4;
	assign ax_d[0] = ax_s4; assign sh_d[0] = spin_s4; assign ah_d[0] = axang_s4;

	for (genvar i = 0; i < NIT; i++) begin : g_cordic
		pbt_cordic_cell #(.VW(VW), .IDX(i)) u_cell (
			.clk(clk), .en(adv), .x_in(cx[i]), .y_in(cy[i]), .z_in(cz[i]),
			.x_out(cx[i+1]), .y_out(cy[i+1]), .z_out(cz[i+1]));
		always_ff @(posedge clk) begin
			if (adv) begin
				pos_d[i+1] <= pos_d[i]; arr_d[i+1] <= arr_d[i]; ss_d[i+1] <= ss_d[i];
				ax_d[i+1] <= ax_d[i]; sh_d[i+1] <= sh_d[i]; ah_d[i+1] <= ah_d[i];
			end
		end
	end

	// output stage
	logic signed [HEADING_WIDTH-1:0] hd_q;
	logic signed [W-1:0]             po_q [3];
	logic                            arr_q;
	always_ff @(posedge clk) begin
		if (adv) begin
			logic signed [ANG_WIDTH-1:0] zr;
			zr = (cz[NIT] + (ANG_WIDTH'(1) <<< (ANG_FRAC - 1))) >>> ANG_FRAC;
			if (ss_d[NIT]) hd_q <= sh_d[NIT];
			else if (ax_d[NIT]) hd_q <= ah_d[NIT];
			else hd_q <= HEADING_WIDTH'(zr);
			po_q  <= pos_d[NIT];
			arr_q <= arr_d[NIT];
		end
	end

	assign m_axis_tdata = OW'({hd_q, po_q[2], po_q[1], po_q[0]});
	assign m_axis_tuser = arr_q;

endmodule

// ----- sv/pbt_lerp_cell.sv -----
// ----------------------------------------------------------------------------
// pbt_lerp_cell: one de Casteljau level
// Interpolates N point pairs at a common t; registered output.
// ----------------------------------------------------------------------------
module pbt_lerp_cell import pbt_pkg::*; #(
	parameter int W = 24,
	parameter int F = 16,
	parameter int N = 3
) (
	input  logic                clk,
	input  logic                en,
	input  logic [F:0]          t,
	input  logic signed [W-1:0] a [N],
	input  logic signed [W-1:0] b [N],
	output logic signed [W-1:0] y [N]
);

	localparam int PW = W + F + 3;

	logic signed [W-1:0] r [N];

	always_comb begin
		for (int i = 0; i < N; i++) begin
			logic signed [W:0]    d;
			logic signed [PW-1:0] p;
			d = (W+1)'(b[i]) - (W+1)'(a[i]);
			p = PW'(d) * $signed({1'b0, t}) + (PW'(1) <<< (F - 1));
			r[i] = W'(PW'(a[i]) + (p >>> F));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			y <= r;
		end
	end

endmodule

// ----- sv/pbt_cordic_cell.sv -----
// ----------------------------------------------------------------------------
// pbt_cordic_cell: one vectoring CORDIC rotation
// Shift amount fixed by the cell's place in the row.
// ----------------------------------------------------------------------------
module pbt_cordic_cell import pbt_pkg::*; #(
	parameter int VW  = 30,
	parameter int IDX = 0
) (
	input  logic                        clk,
	input  logic                        en,
	input  logic signed [VW-1:0]        x_in,
	input  logic signed [VW-1:0]        y_in,
	input  logic signed [ANG_WIDTH-1:0] z_in,
	output logic signed [VW-1:0]        x_out,
	output logic signed [VW-1:0]        y_out,
	output logic signed [ANG_WIDTH-1:0] z_out
);

	always_ff @(posedge clk) begin
		if (en) begin
			if (y_in > 0) begin
				x_out <= x_in + (y_in >>> IDX);
				y_out <= y_in - (x_in >>> IDX);
				z_out <= z_in + atan_entry(IDX);
			end else begin
				x_out <= x_in - (y_in >>> IDX);
				y_out <= y_in + (x_in >>> IDX);
				z_out <= z_in - atan_entry(IDX);
			end
		end
	end

endmodule
